### sv/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// shared constants, types and helpers of the cosine prototype classifier
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int VECTOR_DIM  = 16;
    localparam int ENTRIES     = NUM_CLASSES * VECTOR_DIM;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int CLS_W       = 3;
    localparam int EL_W        = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
    localparam int POS_W       = $clog2(VECTOR_DIM + 1);
    localparam int CNT_W       = $clog2(NUM_CLASSES + 1);
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 16;
    localparam int TEMP_W      = 16;
    localparam int SUM_W       = 28;
    localparam int DOT_W       = 48;
    localparam int NORM_W      = 40;
    localparam int ROOT_W      = NORM_W / 2;
    localparam int DEN_W       = 2 * ROOT_W;
    localparam int DIV_W       = 48;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);
    localparam int COUNT_W     = 12;
    localparam int SIM_W       = 22;
    localparam int LOG2E_W     = 13;
    localparam int PROD_W      = SIM_W + LOG2E_W;
    localparam int E_W         = 17;
    localparam int TOTAL_W     = 20;
    localparam int PROB_W      = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [LOG2E_W-1:0] LOG2E_Q12 = 13'd5909;

    typedef enum logic [1:0] {
        FUNC_WRITE    = 2'd0,
        FUNC_CLASSIFY = 2'd1,
        FUNC_TRAIN    = 2'd2,
        FUNC_COMMIT   = 2'd3
    } func_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input int cls, input int el);
        return ADDR_W'(cls * VECTOR_DIM + el);
    endfunction

endpackage

`default_nettype wire

### sv/cpc_div.sv
// ----------------------------------------------------------------------------
// cpc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [cpc_pkg::DIV_W-1:0] dividend,
    input  wire logic [cpc_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [cpc_pkg::DIV_W-1:0]      quotient
);
    import cpc_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### sv/cpc_isqrt.sv
// ----------------------------------------------------------------------------
// cpc_isqrt
// floor integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cpc_pkg::NORM_W-1:0] radicand,
    output logic                            done,
    output logic [cpc_pkg::ROOT_W-1:0]      root
);
    import cpc_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic [NORM_W-1:0]     rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[NORM_W-1:NORM_W-2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQRT_CNT_W'(ROOT_W - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[NORM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### sv/cosine_prototype_classifier_unit.sv
// ----------------------------------------------------------------------------
// cosine_prototype_classifier_unit
// prototype classifier with cosine similarity and softmax output
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low; func selects a
//   prototype element write, a classify element, a training element or a
//   commit of the class means. temperature is written through
//   cfg_we/cfg_data, by the user, only while the block is idle; the block
//   itself does not enforce this. in a classify element the single
//   prototype ram read port serves one class per cycle into one shared
//   multiply-accumulate. a training element reads, adds and writes back
//   to the sums ram. the final classify element then runs the scoring
//   sequence: a square root of the input norm, then per class a 16-read
//   norm sweep, a bit-serial square root and two divisions (none when the
//   denominator is zero), then the exponentials and one division per
//   class. results come one per class in class order, each shown for one
//   cycle with result_valid, last_result on the final one. a commit walks
//   all prototype entries, through the divider for an entry of a trained
//   class and past it for an untrained one. after reset a clearing pass
//   zeroes all 128 entries of both rams; busy is high meanwhile. the
//   receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_prototype_classifier_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       func,
    input  wire logic [cpc_pkg::CLS_W-1:0]        class_sel,
    input  wire logic [cpc_pkg::IDX_W-1:0]        index,
    input  wire logic signed [cpc_pkg::VAL_W-1:0] value,
    input  wire logic                             last,
    input  wire logic                             cfg_we,
    input  wire logic [cpc_pkg::TEMP_W-1:0]       cfg_data,
    output logic                                  result_valid,
    output logic [cpc_pkg::CLS_W-1:0]             class_index,
    output logic [cpc_pkg::PROB_W-1:0]            probability,
    output logic                                  last_result
);
    import cpc_pkg::*;

    typedef enum logic [17:0] {
        S_CLEAR  = 18'b1 << 0,
        S_IDLE   = 18'b1 << 1,
        S_MAC    = 18'b1 << 2,
        S_TRD    = 18'b1 << 3,
        S_TWR    = 18'b1 << 4,
        S_CM_RD  = 18'b1 << 5,
        S_CM_CHK = 18'b1 << 6,
        S_CM_DIV = 18'b1 << 7,
        S_CM_WR  = 18'b1 << 8,
        S_CL_SZ  = 18'b1 << 9,
        S_CL_NP  = 18'b1 << 10,
        S_CL_SQ  = 18'b1 << 11,
        S_CL_DEN = 18'b1 << 12,
        S_CL_COS = 18'b1 << 13,
        S_CL_SIM = 18'b1 << 14,
        S_CL_EXP = 18'b1 << 15,
        S_CL_PD  = 18'b1 << 16,
        S_CL_PW  = 18'b1 << 17
    } state_t;

    // memories
    logic signed [VAL_W-1:0] proto_mem [ENTRIES];
    logic signed [SUM_W-1:0] sum_mem [ENTRIES];
    logic signed [VAL_W-1:0] proto_rdata_reg;
    logic signed [SUM_W-1:0] sum_rdata_reg;
    logic                    proto_we, sum_we;
    logic [ADDR_W-1:0]       proto_waddr, proto_raddr, sum_waddr, sum_raddr;
    logic signed [VAL_W-1:0] proto_wdata;
    logic signed [SUM_W-1:0] sum_wdata;

    // state registers
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic                    lastf_reg, lastf_next;
    logic [CLS_W-1:0]        latch_reg, latch_next;
    logic [ADDR_W-1:0]       tr_addr_reg, tr_addr_next;
    logic [CNT_W-1:0]        step_reg, step_next;
    logic [CLS_W-1:0]        ccnt_reg, ccnt_next;
    logic [POS_W-1:0]        ecnt_reg, ecnt_next;
    logic [NORM_W-1:0]       np_reg, np_next;
    logic [ROOT_W-1:0]       sz_reg, sz_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic                    cos_neg_reg, cos_neg_next;
    logic signed [SIM_W-1:0] mx_reg, mx_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [CLS_W-1:0]        cm_cls_reg, cm_cls_next;
    logic [EL_W-1:0]         cm_el_reg, cm_el_next;
    logic                    cm_neg_reg, cm_neg_next;
    logic                    cm_wrp_reg, cm_wrp_next;
    logic signed [VAL_W-1:0] mean_reg, mean_next;
    logic [TEMP_W-1:0]       temp_reg, temp_next;
    logic [NORM_W-1:0]       nz_reg, nz_next;
    logic signed [DOT_W-1:0] dot_reg [NUM_CLASSES];
    logic signed [DOT_W-1:0] dot_next [NUM_CLASSES];
    logic signed [SIM_W-1:0] sim_reg [NUM_CLASSES];
    logic signed [SIM_W-1:0] sim_next [NUM_CLASSES];
    logic [E_W-1:0]          e_reg [NUM_CLASSES];
    logic [E_W-1:0]          e_next [NUM_CLASSES];
    logic [COUNT_W-1:0]      count_reg [NUM_CLASSES];
    logic [COUNT_W-1:0]      count_next [NUM_CLASSES];
    logic                    res_valid_reg, res_valid_next;
    logic [CLS_W-1:0]        res_class_reg, res_class_next;
    logic [PROB_W-1:0]       res_prob_reg, res_prob_next;
    logic                    res_last_reg, res_last_next;

    // shared units
    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_num, div_den, div_quot;
    logic                sqrt_start, sqrt_done;
    logic [NORM_W-1:0]   sqrt_in;
    logic [ROOT_W-1:0]   sqrt_root;

    // datapath helpers
    logic signed [2*VAL_W-1:0] sq_in, sq_proto, mac_prod;
    logic [CLS_W-1:0]          lab;
    logic [CLS_W-1:0]          cnt_idx;
    logic                      take;
    logic [TEMP_W-1:0]         tau;
    logic signed [DOT_W-1:0]   dot_sel;
    logic [DOT_W-1:0]          dot_mag;
    logic [NORM_W-1:0]         np_sum;
    logic [SUM_W-1:0]          sum_mag;
    logic [12:0]               cos_q;
    logic signed [SIM_W:0]     diff;
    logic [PROD_W-12-1:0]      u_val;
    logic [E_W-1:0]            e_val;
    logic [17:0]               e_base;
    logic [CLS_W-1:0]          mac_idx;
    logic [CLS_W-1:0]          exp_idx;
    logic                      sim_wr;
    logic signed [SIM_W-1:0]   sim_wdata;
    logic [DIV_W-1:0]          mean_q;

    cpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    cpc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge clk)
    begin
        if (proto_we)
            proto_mem[proto_waddr] <= proto_wdata;
        proto_rdata_reg <= proto_mem[proto_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    assign sq_in    = value * value;
    assign sq_proto = proto_rdata_reg * proto_rdata_reg;
    assign mac_prod = val_reg * proto_rdata_reg;
    assign lab      = (pos_reg == '0) ? class_sel : latch_reg;
    assign cnt_idx  = (state_reg == S_IDLE) ? lab : cm_cls_reg;
    assign take     = (int'(lab) < NUM_CLASSES) && (count_reg[cnt_idx] != COUNT_MAX);
    assign tau      = (temp_reg == '0) ? TEMP_W'(1) : temp_reg;
    assign dot_sel  = dot_reg[ccnt_reg];
    assign dot_mag  = dot_sel[DOT_W-1] ? DOT_W'(-dot_sel) : DOT_W'(dot_sel);
    assign np_sum   = np_reg + ((ecnt_reg != '0) ? NORM_W'($unsigned(sq_proto)) : '0);
    assign sum_mag  = sum_rdata_reg[SUM_W-1] ? SUM_W'(-sum_rdata_reg)
                                             : SUM_W'(sum_rdata_reg);
    assign cos_q    = (div_quot > DIV_W'(4096)) ? 13'd4096 : div_quot[12:0];
    assign mac_idx  = CLS_W'(step_reg - 1'b1);
    assign exp_idx  = step_reg[CLS_W-1:0];
    assign diff     = (SIM_W+1)'(mx_reg) - (SIM_W+1)'(sim_reg[exp_idx]);

    // 2^-y by the chord on each octave
    assign u_val    = (PROD_W-12)'((prod_reg + PROD_W'(2048)) >> 12);
    assign e_base   = 18'd65536 - {3'b000, u_val[11:0], 3'b000};
    assign e_val    = (u_val[PROD_W-12-1:12] > 11'd16) ? '0
                    : E_W'(e_base >> u_val[16:12]);

    // rounded mean, saturated to the element range
    assign mean_q   = div_quot;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        lastf_next     = lastf_reg;
        latch_next     = latch_reg;
        tr_addr_next   = tr_addr_reg;
        step_next      = step_reg;
        ccnt_next      = ccnt_reg;
        ecnt_next      = ecnt_reg;
        np_next        = np_reg;
        sz_next        = sz_reg;
        den_next       = den_reg;
        cos_neg_next   = cos_neg_reg;
        mx_next        = mx_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        cm_cls_next    = cm_cls_reg;
        cm_el_next     = cm_el_reg;
        cm_neg_next    = cm_neg_reg;
        cm_wrp_next    = cm_wrp_reg;
        mean_next      = mean_reg;
        temp_next      = cfg_we ? cfg_data : temp_reg;
        nz_next        = nz_reg;
        dot_next       = dot_reg;
        sim_next       = sim_reg;
        e_next         = e_reg;
        count_next     = count_reg;
        res_valid_next = 1'b0;
        res_class_next = res_class_reg;
        res_prob_next  = res_prob_reg;
        res_last_next  = res_last_reg;
        proto_we       = 1'b0;
        proto_waddr    = '0;
        proto_wdata    = '0;
        proto_raddr    = '0;
        sum_we         = 1'b0;
        sum_waddr      = '0;
        sum_wdata      = '0;
        sum_raddr      = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        sqrt_start     = 1'b0;
        sqrt_in        = '0;
        sim_wr         = 1'b0;
        sim_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                proto_we    = 1'b1;
                proto_waddr = clr_reg;
                sum_we      = 1'b1;
                sum_waddr   = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(ENTRIES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    val_next   = value;
                    lastf_next = last;
                    unique case (func_t'(func))
                        FUNC_WRITE:
                        begin
                            if (int'(class_sel) < NUM_CLASSES && int'(index) < VECTOR_DIM)
                            begin
                                proto_we    = 1'b1;
                                proto_waddr = mem_addr(int'(class_sel), int'(index));
                                proto_wdata = value;
                            end
                        end
                        FUNC_CLASSIFY:
                        begin
                            if (pos_reg < POS_W'(VECTOR_DIM))
                            begin
                                nz_next    = nz_reg + NORM_W'($unsigned(sq_in));
                                step_next  = '0;
                                state_next = S_MAC;
                            end
                            else if (last)
                            begin
                                sqrt_start = 1'b1;
                                sqrt_in    = nz_reg;
                                ccnt_next  = '0;
                                state_next = S_CL_SZ;
                            end
                        end
                        FUNC_TRAIN:
                        begin
                            latch_next   = lab;
                            tr_addr_next = mem_addr(int'(lab), int'(pos_reg[EL_W-1:0]));
                            if (pos_reg < POS_W'(VECTOR_DIM))
                            begin
                                pos_next = pos_reg + 1'b1;
                                if (take)
                                    state_next = S_TRD;
                            end
                            if (last)
                            begin
                                if (take)
                                    count_next[lab] = count_reg[lab] + 1'b1;
                                pos_next = '0;
                                nz_next  = '0;
                                for (int i = 0; i < NUM_CLASSES; i++)
                                    dot_next[i] = '0;
                            end
                        end
                        FUNC_COMMIT:
                        begin
                            cm_cls_next = '0;
                            cm_el_next  = '0;
                            state_next  = S_CM_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                if (step_reg < CNT_W'(NUM_CLASSES))
                    proto_raddr = mem_addr(int'(exp_idx), int'(pos_reg[EL_W-1:0]));
                if (step_reg != '0)
                    dot_next[mac_idx] = dot_reg[mac_idx] + DOT_W'(mac_prod);
                if (step_reg == CNT_W'(NUM_CLASSES))
                begin
                    pos_next = pos_reg + 1'b1;
                    if (lastf_reg)
                    begin
                        sqrt_start = 1'b1;
                        sqrt_in    = nz_reg;
                        ccnt_next  = '0;
                        state_next = S_CL_SZ;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_TRD:
            begin
                sum_raddr  = tr_addr_reg;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                sum_we     = 1'b1;
                sum_waddr  = tr_addr_reg;
                sum_wdata  = sum_rdata_reg + SUM_W'(val_reg);
                state_next = S_IDLE;
            end
            S_CM_RD:
            begin
                sum_raddr  = mem_addr(int'(cm_cls_reg), int'(cm_el_reg));
                state_next = S_CM_CHK;
            end
            S_CM_CHK:
            begin
                if (count_reg[cnt_idx] == '0)
                begin
                    cm_wrp_next = 1'b0;
                    state_next  = S_CM_WR;
                end
                else
                begin
                    div_start   = 1'b1;
                    div_num     = DIV_W'(sum_mag) + DIV_W'(count_reg[cnt_idx] >> 1);
                    div_den     = DIV_W'(count_reg[cnt_idx]);
                    cm_neg_next = sum_rdata_reg[SUM_W-1];
                    state_next  = S_CM_DIV;
                end
            end
            S_CM_DIV:
            begin
                if (div_done)
                begin
                    if (cm_neg_reg)
                        mean_next = (mean_q >= DIV_W'(32768)) ? 16'sh8000
                                  : VAL_W'(-$signed({1'b0, mean_q[VAL_W-2:0]}));
                    else
                        mean_next = (mean_q > DIV_W'(32767)) ? 16'sh7fff
                                  : $signed(mean_q[VAL_W-1:0]);
                    cm_wrp_next = 1'b1;
                    state_next  = S_CM_WR;
                end
            end
            S_CM_WR:
            begin
                sum_we    = 1'b1;
                sum_waddr = mem_addr(int'(cm_cls_reg), int'(cm_el_reg));
                if (cm_wrp_reg)
                begin
                    proto_we    = 1'b1;
                    proto_waddr = mem_addr(int'(cm_cls_reg), int'(cm_el_reg));
                    proto_wdata = mean_reg;
                end
                state_next = S_CM_RD;
                if (cm_el_reg == EL_W'(VECTOR_DIM - 1))
                begin
                    cm_el_next = '0;
                    if (cm_cls_reg == CLS_W'(NUM_CLASSES - 1))
                    begin
                        for (int i = 0; i < NUM_CLASSES; i++)
                            count_next[i] = '0;
                        state_next = S_IDLE;
                    end
                    else
                        cm_cls_next = cm_cls_reg + 1'b1;
                end
                else
                    cm_el_next = cm_el_reg + 1'b1;
            end
            S_CL_SZ:
            begin
                if (sqrt_done)
                begin
                    sz_next    = sqrt_root;
                    ecnt_next  = '0;
                    np_next    = '0;
                    state_next = S_CL_NP;
                end
            end
            S_CL_NP:
            begin
                if (ecnt_reg < POS_W'(VECTOR_DIM))
                    proto_raddr = mem_addr(int'(ccnt_reg), int'(ecnt_reg[EL_W-1:0]));
                if (ecnt_reg == POS_W'(VECTOR_DIM))
                begin
                    sqrt_start = 1'b1;
                    sqrt_in    = np_sum;
                    state_next = S_CL_SQ;
                end
                else
                begin
                    np_next   = np_sum;
                    ecnt_next = ecnt_reg + 1'b1;
                end
            end
            S_CL_SQ:
            begin
                if (sqrt_done)
                begin
                    den_next   = sz_reg * sqrt_root;
                    state_next = S_CL_DEN;
                end
            end
            S_CL_DEN:
            begin
                if (den_reg == '0)
                begin
                    sim_wr    = 1'b1;
                    sim_wdata = '0;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_num      = DIV_W'(dot_mag << 12) + DIV_W'(den_reg >> 1);
                    div_den      = DIV_W'(den_reg);
                    cos_neg_next = dot_sel[DOT_W-1];
                    state_next   = S_CL_COS;
                end
            end
            S_CL_COS:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_W'({cos_q, 8'b0}) + DIV_W'(tau >> 1);
                    div_den    = DIV_W'(tau);
                    state_next = S_CL_SIM;
                end
            end
            S_CL_SIM:
            begin
                if (div_done)
                begin
                    sim_wr    = 1'b1;
                    sim_wdata = cos_neg_reg ? -$signed(div_quot[SIM_W-1:0])
                                            : $signed(div_quot[SIM_W-1:0]);
                end
            end
            S_CL_EXP:
            begin
                if (step_reg < CNT_W'(NUM_CLASSES))
                    prod_next = PROD_W'(diff[SIM_W-1:0]) * PROD_W'(LOG2E_Q12);
                if (step_reg != '0)
                begin
                    e_next[mac_idx] = e_val;
                    total_next      = total_reg + TOTAL_W'(e_val);
                end
                if (step_reg == CNT_W'(NUM_CLASSES))
                begin
                    ccnt_next  = '0;
                    state_next = S_CL_PD;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_CL_PD:
            begin
                div_start  = 1'b1;
                div_num    = DIV_W'({e_reg[ccnt_reg], 16'b0}) + DIV_W'(total_reg >> 1);
                div_den    = DIV_W'(total_reg);
                state_next = S_CL_PW;
            end
            S_CL_PW:
            begin
                if (div_done)
                begin
                    res_valid_next = 1'b1;
                    res_class_next = ccnt_reg;
                    res_prob_next  = (div_quot > DIV_W'(65535)) ? 16'hffff
                                                                : div_quot[PROB_W-1:0];
                    res_last_next  = (ccnt_reg == CLS_W'(NUM_CLASSES - 1));
                    if (ccnt_reg == CLS_W'(NUM_CLASSES - 1))
                    begin
                        pos_next = '0;
                        nz_next  = '0;
                        for (int i = 0; i < NUM_CLASSES; i++)
                            dot_next[i] = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ccnt_next  = ccnt_reg + 1'b1;
                        state_next = S_CL_PD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one similarity done: keep the maximum and move to the next class, or to the exponentials after the last one
        if (sim_wr)
        begin
            sim_next[ccnt_reg] = sim_wdata;
            if (ccnt_reg == '0 || sim_wdata > mx_reg)
                mx_next = sim_wdata;
            if (ccnt_reg == CLS_W'(NUM_CLASSES - 1))
            begin
                step_next  = '0;
                total_next = '0;
                state_next = S_CL_EXP;
            end
            else
            begin
                ccnt_next  = ccnt_reg + 1'b1;
                ecnt_next  = '0;
                np_next    = '0;
                state_next = S_CL_NP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            lastf_reg     <= 1'b0;
            latch_reg     <= '0;
            step_reg      <= '0;
            ccnt_reg      <= '0;
            ecnt_reg      <= '0;
            cm_cls_reg    <= '0;
            cm_el_reg     <= '0;
            cm_wrp_reg    <= 1'b0;
            temp_reg      <= TEMP_W'(256);
            nz_reg        <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                dot_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            lastf_reg     <= lastf_next;
            latch_reg     <= latch_next;
            step_reg      <= step_next;
            ccnt_reg      <= ccnt_next;
            ecnt_reg      <= ecnt_next;
            cm_cls_reg    <= cm_cls_next;
            cm_el_reg     <= cm_el_next;
            cm_wrp_reg    <= cm_wrp_next;
            temp_reg      <= temp_next;
            nz_reg        <= nz_next;
            res_valid_reg <= res_valid_next;
            dot_reg       <= dot_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        tr_addr_reg   <= tr_addr_next;
        np_reg        <= np_next;
        sz_reg        <= sz_next;
        den_reg       <= den_next;
        cos_neg_reg   <= cos_neg_next;
        mx_reg        <= mx_next;
        total_reg     <= total_next;
        prod_reg      <= prod_next;
        cm_neg_reg    <= cm_neg_next;
        mean_reg      <= mean_next;
        sim_reg       <= sim_next;
        e_reg         <= e_next;
        res_class_reg <= res_class_next;
        res_prob_reg  <= res_prob_next;
        res_last_reg  <= res_last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign class_index  = res_class_reg;
    assign probability  = res_prob_reg;
    assign last_result  = res_last_reg;

endmodule

`default_nettype wire
